[rtl/core/tsrg_pkg.sv]
package tsrg_pkg;

  localparam int PulseW    = 12;
  localparam int MarginW   = 8;
  localparam int BaseW     = 16;
  localparam int ThreshW   = 23;
  localparam int RpmW      = 24;
  localparam int TimeW     = 32;
  localparam int LimitW    = BaseW + MarginW;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 23;
  localparam int InDataW   = 72;
  localparam int InFieldsW = 1 + PulseW + RpmW + TimeW;
  localparam int OutDataW  = 16;

  localparam logic [PulseW-1:0]  PulseMax          = 12'hFFF;
  localparam logic [PulseW-1:0]  NeutralPulseReset = 12'd1500;
  localparam logic [MarginW-1:0] ArmMarginReset    = 8'd50;
  localparam logic [MarginW-1:0] DriveMarginReset  = 8'd50;
  localparam logic [MarginW-1:0] RampStepReset     = 8'd10;
  localparam logic [BaseW-1:0]   RampBaseReset     = 16'd50;
  localparam logic [ThreshW-1:0] RpmThresholdReset = 23'd200;
  localparam logic [PulseW-1:0]  MinPulseReset     = 12'd1000;

  typedef enum logic [CfgAddrW-1:0] {
    REG_NEUTRAL_PULSE     = 3'd0,
    REG_ARM_MARGIN        = 3'd1,
    REG_DRIVE_MARGIN      = 3'd2,
    REG_RAMP_STEP         = 3'd3,
    REG_RAMP_BASE_MS      = 3'd4,
    REG_RPM_THRESHOLD     = 3'd5,
    REG_MIN_PULSE         = 3'd6,
    REG_AUTO_DECEL_ENABLE = 3'd7
  } cfg_idx_t;

  // Configuration as seen by the step logic; ramp_limit is base * step, registered.
  typedef struct packed {
    logic [PulseW-1:0]  neutral_pulse;
    logic [MarginW-1:0] arm_margin;
    logic [MarginW-1:0] drive_margin;
    logic [MarginW-1:0] ramp_step;
    logic [ThreshW-1:0] rpm_threshold;
    logic [PulseW-1:0]  min_pulse;
    logic               auto_decel_enable;
    logic [LimitW-1:0]  ramp_limit;
  } cfg_t;

  typedef struct packed {
    logic [PulseW-1:0]      drive;
    logic                   armed;
    logic                   released;
    logic [TimeW-1:0]       last_ramp;
    logic signed [RpmW-1:0] prev_rpm;
  } state_t;

  // Declared MSB first, so the first field lands in the highest bits.
  typedef struct packed {
    logic [TimeW-1:0]       now_ms;
    logic signed [RpmW-1:0] motor_rpm;
    logic [PulseW-1:0]      remote_throttle;
    logic                   link_ok;
  } item_t;

  // Strict window around neutral: v - m < n and v + m > n.
  function automatic logic in_window(logic [PulseW-1:0] v, logic [MarginW-1:0] m,
                                     logic [PulseW-1:0] n);
    logic [PulseW:0] v_ext;
    logic [PulseW:0] n_ext;
    logic [PulseW:0] m_ext;
    v_ext = {1'b0, v};
    n_ext = {1'b0, n};
    m_ext = {{(PulseW + 1 - MarginW){1'b0}}, m};
    return (v_ext < n_ext + m_ext) && (v_ext + m_ext > n_ext);
  endfunction

endpackage

[rtl/core/tsrg_step.sv]
module tsrg_step (
  input  tsrg_pkg::cfg_t   cfg,
  input  tsrg_pkg::state_t state,
  input  tsrg_pkg::item_t  item,
  output tsrg_pkg::state_t state_nxt
);

  logic [tsrg_pkg::PulseW-1:0] drive1;
  logic                        armed1;
  logic                        take_remote;
  logic                        gated;
  logic                        win_arm;
  logic                        win_safe;
  logic                        fast;
  logic                        due;
  logic                        match;
  logic                        rpm_rising;
  logic [tsrg_pkg::PulseW:0]   drive_ext;
  logic [tsrg_pkg::PulseW:0]   remote_ext;
  logic [tsrg_pkg::PulseW:0]   step_ext;
  logic [tsrg_pkg::PulseW:0]   margin_ext;
  logic [tsrg_pkg::PulseW:0]   up_sum;
  logic [tsrg_pkg::PulseW-1:0] step_up;
  logic [tsrg_pkg::PulseW-1:0] step_down;
  logic [tsrg_pkg::PulseW-1:0] lost_down;
  logic [tsrg_pkg::TimeW-1:0]  elapsed;

  assign win_arm     = tsrg_pkg::in_window(item.remote_throttle, cfg.arm_margin,
                                           cfg.neutral_pulse);
  assign take_remote = item.link_ok && state.armed && state.released;
  assign drive1      = take_remote ? item.remote_throttle : state.drive;
  assign armed1      = state.armed || (item.link_ok && win_arm);
  assign gated       = !item.link_ok || !armed1 || !state.released;
  assign win_safe    = tsrg_pkg::in_window(drive1, cfg.drive_margin, cfg.neutral_pulse);

  assign fast = $signed({item.motor_rpm[tsrg_pkg::RpmW-1], item.motor_rpm}) >
                $signed({1'b0, cfg.rpm_threshold, 1'b0});

  assign elapsed = item.now_ms - state.last_ramp;
  assign due     = elapsed > {{(tsrg_pkg::TimeW - tsrg_pkg::LimitW){1'b0}}, cfg.ramp_limit};

  assign drive_ext  = {1'b0, drive1};
  assign remote_ext = {1'b0, item.remote_throttle};
  assign step_ext   = {{(tsrg_pkg::PulseW + 1 - tsrg_pkg::MarginW){1'b0}}, cfg.ramp_step};
  assign margin_ext = {{(tsrg_pkg::PulseW + 1 - tsrg_pkg::MarginW){1'b0}}, cfg.drive_margin};

  // Remote within drive +/- drive_margin, rearranged to stay unsigned.
  assign match = (remote_ext + margin_ext >= drive_ext) &&
                 (remote_ext <= drive_ext + margin_ext);

  assign up_sum    = drive_ext + step_ext;
  assign step_up   = up_sum[tsrg_pkg::PulseW] ? tsrg_pkg::PulseMax
                                              : up_sum[tsrg_pkg::PulseW-1:0];
  assign step_down = (drive_ext > step_ext) ? drive1 - step_ext[tsrg_pkg::PulseW-1:0]
                                            : '0;
  // Link-lost ramp down is floored at min_pulse; a drive below the floor is raised to it.
  assign lost_down = (drive_ext < {1'b0, cfg.min_pulse} + step_ext)
                     ? cfg.min_pulse
                     : drive1 - step_ext[tsrg_pkg::PulseW-1:0];
  assign rpm_rising = item.motor_rpm > state.prev_rpm;

  always_comb begin
    state_nxt       = state;
    state_nxt.drive = drive1;
    state_nxt.armed = armed1;
    if (gated) begin
      if (!win_safe) begin
        state_nxt.armed = 1'b0;
      end
      if (cfg.auto_decel_enable) begin
        if (fast) begin
          state_nxt.released = 1'b0;
          if (due) begin
            state_nxt.last_ramp = item.now_ms;
            if (item.link_ok) begin
              if (match) begin
                state_nxt.armed    = 1'b1;
                state_nxt.released = 1'b1;
              end else if (item.remote_throttle > drive1) begin
                state_nxt.drive = step_up;
              end else if (item.remote_throttle < drive1) begin
                state_nxt.drive = step_down;
              end
            end else begin
              if (rpm_rising || drive1 > cfg.neutral_pulse) begin
                state_nxt.drive = lost_down;
              end
              state_nxt.prev_rpm = item.motor_rpm;
            end
          end
        end else if (!win_safe) begin
          if (due) begin
            state_nxt.last_ramp = item.now_ms;
            state_nxt.drive     = (drive1 < cfg.neutral_pulse) ? step_up : step_down;
          end
        end else begin
          state_nxt.released = 1'b1;
        end
      end else begin
        state_nxt.drive    = cfg.neutral_pulse;
        state_nxt.released = 1'b1;
      end
    end
  end

endmodule

[rtl/core/throttle_safety_ramp_gate_top.sv]
// Throttle safety gate with arming, release and drive ramping.
// The in_ stream carries one control tick per request: link status, remote
// throttle pulse, motor rpm and a millisecond timestamp. The out_ stream
// returns one request per tick with the drive pulse and the armed and
// released flags as they stand after that tick.
// A request accepted into the input register passes through the step logic
// into the result register, from which the receiver takes it. Throughput is
// one request per cycle while the receiver does not stall; the step logic
// is a single pass of compares and adds between the input register and the
// result register. When the receiver stalls, the result register holds, the
// input register fills, and in_tready drops only while both are occupied.
// The cfg_ port writes register cfg_addr with cfg_wdata whenever cfg_we is
// high; write it only while the block is idle. The ramp interval product is
// registered in the cycle after a write.
// Synchronous active-low reset returns the cfg_ registers to their defaults,
// sets the drive to 1500, clears both flags and empties both stages.
module throttle_safety_ramp_gate_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // link_ok[0], remote_throttle[12:1], motor_rpm[36:13], now_ms[68:37], zero fill
  input  logic [tsrg_pkg::InDataW-1:0]    in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // drive_pulse[11:0], armed[12], released[13], zero fill
  output logic [tsrg_pkg::OutDataW-1:0]   out_tdata,
  input  logic                            cfg_we,
  input  logic [tsrg_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [tsrg_pkg::CfgDataW-1:0]   cfg_wdata
);

  logic [tsrg_pkg::PulseW-1:0]  neutral_pulse_r;
  logic [tsrg_pkg::MarginW-1:0] arm_margin_r;
  logic [tsrg_pkg::MarginW-1:0] drive_margin_r;
  logic [tsrg_pkg::MarginW-1:0] ramp_step_r;
  logic [tsrg_pkg::BaseW-1:0]   ramp_base_r;
  logic [tsrg_pkg::ThreshW-1:0] rpm_threshold_r;
  logic [tsrg_pkg::PulseW-1:0]  min_pulse_r;
  logic                         auto_decel_r;
  logic [tsrg_pkg::LimitW-1:0]  ramp_limit_r;

  tsrg_pkg::cfg_t   cfg;
  tsrg_pkg::state_t state_r;
  tsrg_pkg::state_t state_nxt;
  tsrg_pkg::item_t  s1_item_r;
  logic             s1_valid_r;
  logic             out_valid_r;
  logic [tsrg_pkg::OutDataW-1:0] out_data_r;
  logic             advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_pulse_r <= tsrg_pkg::NeutralPulseReset;
      arm_margin_r    <= tsrg_pkg::ArmMarginReset;
      drive_margin_r  <= tsrg_pkg::DriveMarginReset;
      ramp_step_r     <= tsrg_pkg::RampStepReset;
      ramp_base_r     <= tsrg_pkg::RampBaseReset;
      rpm_threshold_r <= tsrg_pkg::RpmThresholdReset;
      min_pulse_r     <= tsrg_pkg::MinPulseReset;
      auto_decel_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (tsrg_pkg::cfg_idx_t'(cfg_addr))
        tsrg_pkg::REG_NEUTRAL_PULSE:     neutral_pulse_r <= cfg_wdata[tsrg_pkg::PulseW-1:0];
        tsrg_pkg::REG_ARM_MARGIN:        arm_margin_r    <= cfg_wdata[tsrg_pkg::MarginW-1:0];
        tsrg_pkg::REG_DRIVE_MARGIN:      drive_margin_r  <= cfg_wdata[tsrg_pkg::MarginW-1:0];
        tsrg_pkg::REG_RAMP_STEP:         ramp_step_r     <= cfg_wdata[tsrg_pkg::MarginW-1:0];
        tsrg_pkg::REG_RAMP_BASE_MS:      ramp_base_r     <= cfg_wdata[tsrg_pkg::BaseW-1:0];
        tsrg_pkg::REG_RPM_THRESHOLD:     rpm_threshold_r <= cfg_wdata[tsrg_pkg::ThreshW-1:0];
        tsrg_pkg::REG_MIN_PULSE:         min_pulse_r     <= cfg_wdata[tsrg_pkg::PulseW-1:0];
        tsrg_pkg::REG_AUTO_DECEL_ENABLE: auto_decel_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Interval product settles before use if cfg_ is written idle; not enforced.
  always_ff @(posedge clk) begin
    ramp_limit_r <= {{(tsrg_pkg::LimitW - tsrg_pkg::BaseW){1'b0}}, ramp_base_r} *
                    {{(tsrg_pkg::LimitW - tsrg_pkg::MarginW){1'b0}}, ramp_step_r};
  end

  assign cfg.neutral_pulse     = neutral_pulse_r;
  assign cfg.arm_margin        = arm_margin_r;
  assign cfg.drive_margin      = drive_margin_r;
  assign cfg.ramp_step         = ramp_step_r;
  assign cfg.rpm_threshold     = rpm_threshold_r;
  assign cfg.min_pulse         = min_pulse_r;
  assign cfg.auto_decel_enable = auto_decel_r;
  assign cfg.ramp_limit        = ramp_limit_r;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= tsrg_pkg::item_t'(in_tdata[tsrg_pkg::InFieldsW-1:0]);
    end
  end

  tsrg_step u_step (
    .cfg       (cfg),
    .state     (state_r),
    .item      (s1_item_r),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.drive     <= tsrg_pkg::NeutralPulseReset;
      state_r.armed     <= 1'b0;
      state_r.released  <= 1'b0;
      state_r.last_ramp <= '0;
      state_r.prev_rpm  <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {2'b00, state_nxt.released, state_nxt.armed, state_nxt.drive};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/core/tsrg_checker.sv]
module tsrg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [tsrg_pkg::OutDataW-1:0] out_tdata
);

  // Both stages come out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // The input side only backs up when a result is waiting on a stalled receiver.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("in_tready low without a stalled result");

  // The padding bits above the flags never carry anything.
  a_out_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[tsrg_pkg::OutDataW-1:tsrg_pkg::PulseW+2] == '0)
    else $error("result padding bits not zero");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind throttle_safety_ramp_gate_top tsrg_checker u_tsrg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
